>>> hdl/spmq_pkg.sv
// Shared types and constants for the strict priority multi-queue.
// No dependencies; used by spmq_queue_ctrl, the top level and the testbench.
package spmq_pkg;

   localparam int DEPTH_DEF  = 16;
   localparam int LEVELS_DEF = 3;

   // CSR map: word index of each register
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam logic CSR_SHUTDOWN = 1'b0;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_PUSHED         = 3'd0,
      ST_DROPPED        = 3'd1,
      ST_POPPED         = 3'd2,
      ST_EMPTY_RETRY    = 3'd3,
      ST_EMPTY_SHUTDOWN = 3'd4
   } status_type;

   typedef struct packed {
      logic        opcode;
      logic [1:0]  priority_req;
      logic [15:0] task_handle;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] popped_handle;
      logic [1:0]  popped_level;
   } rsp_type;

   // Per-request outcome from the queue controller
   typedef struct packed {
      status_type status;
      logic [1:0] level;
      logic       hit;     // pop found an entry; handle comes from the slot RAM
   } res_type;

endpackage

>>> hdl/spmq_slot_ram.sv
// Slot storage for all priority levels: one write port, one registered read port.
// Depends on nothing but its parameters.
module spmq_slot_ram #(
   parameter int ENTRIES = 48,
   parameter int ADDR_W  = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [15:0]       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [15:0]       rd_data
);

   logic [15:0] mem_ff [ENTRIES];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/spmq_queue_ctrl.sv
// Per-level head/tail/count pointers, push/pop decision and slot RAM addressing.
// Depends on spmq_pkg.
module spmq_queue_ctrl #(
   parameter int DEPTH  = spmq_pkg::DEPTH_DEF,
   parameter int LEVELS = spmq_pkg::LEVELS_DEF,
   parameter int ADDR_W = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                op_en,
   input  spmq_pkg::req_type   req,
   input  logic                shutdown,
   output logic                ram_wr_en,
   output logic                ram_rd_en,
   output logic [ADDR_W-1:0]   ram_addr,
   output logic [15:0]         ram_wr_data,
   output spmq_pkg::res_type   res
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   logic [IDX_W-1:0] head_ff [LEVELS];
   logic [IDX_W-1:0] head_in [LEVELS];
   logic [IDX_W-1:0] tail_ff [LEVELS];
   logic [IDX_W-1:0] tail_in [LEVELS];
   logic [CNT_W-1:0] cnt_ff  [LEVELS];
   logic [CNT_W-1:0] cnt_in  [LEVELS];

   logic             is_pop;
   logic             in_range;
   logic             push_ok;
   logic             found;
   logic [LVL_W-1:0] push_lvl;
   logic [LVL_W-1:0] pop_lvl;
   logic [LVL_W-1:0] sel_lvl;
   logic [IDX_W-1:0] sel_idx;

   // priority encoder: lowest non-empty level wins
   always_comb begin
      found   = 1'b0;
      pop_lvl = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (cnt_ff[i] != '0) begin
            found   = 1'b1;
            pop_lvl = LVL_W'(i);
         end
      end
   end

   assign is_pop   = (req.opcode == spmq_pkg::OP_POP);
   assign in_range = ({30'd0, req.priority_req} < 32'(LEVELS));
   assign push_lvl = LVL_W'(req.priority_req);
   assign push_ok  = in_range && (cnt_ff[push_lvl] != CNT_W'(DEPTH));

   // next pointer state
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      if (op_en) begin
         if (is_pop) begin
            if (found) begin
               head_in[pop_lvl] = (head_ff[pop_lvl] == IDX_W'(DEPTH - 1)) ? '0 :
                                  head_ff[pop_lvl] + 1'b1;
               cnt_in[pop_lvl]  = cnt_ff[pop_lvl] - 1'b1;
            end
         end else if (push_ok) begin
            tail_in[push_lvl] = (tail_ff[push_lvl] == IDX_W'(DEPTH - 1)) ? '0 :
                                tail_ff[push_lvl] + 1'b1;
            cnt_in[push_lvl]  = cnt_ff[push_lvl] + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   // RAM access: level base plus ring index
   assign sel_lvl     = is_pop ? pop_lvl : push_lvl;
   assign sel_idx     = is_pop ? head_ff[pop_lvl] : tail_ff[push_lvl];
   assign ram_addr    = ADDR_W'(ADDR_W'(sel_lvl) * ADDR_W'(DEPTH)) + ADDR_W'(sel_idx);
   assign ram_wr_en   = op_en && !is_pop && push_ok;
   assign ram_rd_en   = op_en && is_pop && found;
   assign ram_wr_data = req.task_handle;

   // outcome
   always_comb begin
      res.hit   = 1'b0;
      res.level = 2'd0;
      if (is_pop) begin
         if (found) begin
            res.status = spmq_pkg::ST_POPPED;
            res.level  = 2'(pop_lvl);
            res.hit    = 1'b1;
         end else if (shutdown) begin
            res.status = spmq_pkg::ST_EMPTY_SHUTDOWN;
         end else begin
            res.status = spmq_pkg::ST_EMPTY_RETRY;
         end
      end else if (push_ok) begin
         res.status = spmq_pkg::ST_PUSHED;
      end else begin
         res.status = spmq_pkg::ST_DROPPED;
      end
   end

endmodule

>>> hdl/strict_priority_multi_queue_top.sv
// Top level of the strict priority multi-queue: handshakes, CSR port, result register.
// Depends on spmq_pkg, spmq_slot_ram and spmq_queue_ctrl.
//
// Usage:
//   req_*  : request channel (valid/ready). A request is a push (priority_req,
//            task_handle) or a pop. Level 0 is served first on a pop.
//   rsp_*  : one response per request (valid/ready): status, popped_handle,
//            popped_level. Handle and level are zero unless status is popped.
//   csr_*  : APB-style port, one register at byte 0: bit 0 = shutdown. With
//            shutdown set a pop on empty queues reports shut down, else retry.
// Pipeline:
//   An accepted request passes the pointer update and slot RAM read, which
//   are registered together, and then the response register, from which its
//   response can be taken. A new request is not taken while the last one is
//   in the RAM read stage: req_ready is low in the cycle after an accept.
// Reset (synchronous): all levels empty, shutdown cleared, no response pending.
//   Slot RAM contents are not cleared; only written slots are ever read.
// Stall: while rsp_valid is high and rsp_ready low the response holds and
//   req_ready stays low; no request is lost or reordered.
module strict_priority_multi_queue_top #(
   parameter int DEPTH  = spmq_pkg::DEPTH_DEF,
   parameter int LEVELS = spmq_pkg::LEVELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  spmq_pkg::req_type                 req_data,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output spmq_pkg::rsp_type                 rsp_data,
   // CSR port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [spmq_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [spmq_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [spmq_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int ENTRIES = LEVELS * DEPTH;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // CSR
   logic shutdown_ff;
   logic shutdown_in;
   logic csr_wr;
   logic csr_hit;

   // request/response pipeline
   logic                req_fire;
   logic                s1_valid_ff;
   logic                s1_valid_in;
   spmq_pkg::res_type   s1_res_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   spmq_pkg::rsp_type   rsp_data_ff;
   spmq_pkg::rsp_type   rsp_data_in;

   // controller <-> RAM
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_addr;
   logic [15:0]         ram_wr_data;
   logic [15:0]         ram_rd_data;
   spmq_pkg::res_type   res;

   // ---------------- CSR ----------------
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == spmq_pkg::CSR_SHUTDOWN);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign shutdown_in = (csr_wr && csr_hit) ? csr_pwdata[0] : shutdown_ff;
   assign csr_prdata  = csr_hit ? {31'd0, shutdown_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         shutdown_ff <= 1'b0;
      end else begin
         shutdown_ff <= shutdown_in;
      end
   end

   // ---------------- request side ----------------
   // Accept only when the RAM stage is free and the output register will be
   // empty by the time this request reaches it.
   assign req_ready = !s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   spmq_queue_ctrl #(
      .DEPTH  (DEPTH),
      .LEVELS (LEVELS),
      .ADDR_W (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .op_en       (req_fire),
      .req         (req_data),
      .shutdown    (shutdown_ff),
      .ram_wr_en   (ram_wr_en),
      .ram_rd_en   (ram_rd_en),
      .ram_addr    (ram_addr),
      .ram_wr_data (ram_wr_data),
      .res         (res)
   );

   spmq_slot_ram #(
      .ENTRIES (ENTRIES),
      .ADDR_W  (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------- RAM read stage ----------------
   assign s1_valid_in = req_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_res_ff <= res;
      end
   end

   // ---------------- response register ----------------
   // s1 always finds the output register empty (guaranteed by req_ready).
   always_comb begin
      rsp_data_in.status        = s1_res_ff.status;
      rsp_data_in.popped_level  = s1_res_ff.level;
      rsp_data_in.popped_handle = s1_res_ff.hit ? ram_rd_data : 16'd0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_valid_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> dv/tb_strict_priority_multi_queue_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for strict_priority_multi_queue_top: push/pop traffic
// against a cycle-free model of the three priority FIFOs. Depends on spmq_pkg and the top level.
module tb_strict_priority_multi_queue_top;

   localparam int DEPTH       = spmq_pkg::DEPTH_DEF;
   localparam int LEVELS      = spmq_pkg::LEVELS_DEF;
   localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the block
   localparam int SETTLE      = 8;     // settling margin before idle work
   localparam logic [1:0] BAD_LEVEL = 2'(LEVELS);   // first priority that does not exist
   localparam logic [spmq_pkg::CSR_ADDR_W-1:0] SHUTDOWN_ADDR =
      spmq_pkg::CSR_ADDR_W'(4 * spmq_pkg::CSR_SHUTDOWN);
   localparam logic [spmq_pkg::CSR_ADDR_W-1:0] UNMAPPED_ADDR =
      spmq_pkg::CSR_ADDR_W'(4);   // register index 1

   // DUT ports, all inputs known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   spmq_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   spmq_pkg::rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [spmq_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [spmq_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [spmq_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // Shadow copy of the queues and the shutdown bit
   logic [15:0] slot_copy [LEVELS][DEPTH];
   int head_ptr [LEVELS];
   int tail_ptr [LEVELS];
   int fill_cnt [LEVELS];
   logic shutdown_copy;

   // Responses predicted at request accept, oldest first
   spmq_pkg::rsp_type awaited_rsp [$];

   // Traffic shaping, set per phase by the main sequence
   int send_idle_pct = 0;
   int rcv_idle_pct = 0;
   logic hold_tick = 1'b0;   // toggled to start one long receiver hold-off
   logic hold_seen = 1'b0;
   int hold_left = 0;

   int n_errors = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_popped = 0;
   int n_dropped = 0;
   int n_retry = 0;
   int n_shut = 0;

   strict_priority_multi_queue_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // Predict the response to one request and advance the shadow queues.
   // Push: store at the level's tail unless the level is missing or full.
   // Pop: oldest handle of the lowest-numbered non-empty level, else an empty report.
   function automatic spmq_pkg::rsp_type serve_request(input spmq_pkg::req_type r);
      spmq_pkg::rsp_type res;
      int lvl;
      res = '0;
      if (r.opcode == spmq_pkg::OP_PUSH) begin
         lvl = r.priority_req;
         if (lvl >= LEVELS || fill_cnt[lvl] >= DEPTH) begin
            res.status = spmq_pkg::ST_DROPPED;
         end else begin
            slot_copy[lvl][tail_ptr[lvl]] = r.task_handle;
            tail_ptr[lvl] = (tail_ptr[lvl] + 1) % DEPTH;
            fill_cnt[lvl]++;
            res.status = spmq_pkg::ST_PUSHED;
         end
         return res;
      end
      for (lvl = 0; lvl < LEVELS; lvl++) begin
         if (fill_cnt[lvl] > 0) begin
            res.status = spmq_pkg::ST_POPPED;
            res.popped_handle = slot_copy[lvl][head_ptr[lvl]];
            res.popped_level = 2'(lvl);
            head_ptr[lvl] = (head_ptr[lvl] + 1) % DEPTH;
            fill_cnt[lvl]--;
            return res;
         end
      end
      res.status = shutdown_copy ? spmq_pkg::ST_EMPTY_SHUTDOWN : spmq_pkg::ST_EMPTY_RETRY;
      return res;
   endfunction

   function automatic spmq_pkg::req_type make_req(input spmq_pkg::opcode_type op,
                                                  input logic [1:0] lvl,
                                                  input logic [15:0] handle);
      spmq_pkg::req_type r;
      r.opcode = op;
      r.priority_req = lvl;
      r.task_handle = handle;
      return r;
   endfunction

   // Offer one request, with a random idle gap first; returns at the accept edge
   // with req_valid still high so back-to-back requests get no idle gap between them.
   task automatic send_request(input spmq_pkg::req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      awaited_rsp.push_back(serve_request(r));
      n_sent++;
   endtask

   // Sender goes quiet until every predicted response has been seen.
   task automatic drain_responses;
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // APB write, only with the block idle: setup, then access until pready.
   task automatic write_csr(input logic [spmq_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [spmq_pkg::CSR_DATA_W-1:0] data);
      drain_responses();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == SHUTDOWN_ADDR)
         shutdown_copy = data[0];
   endtask

   // Receiver: random ready, or a counted hold-off when hold_tick flips
   always @(posedge clock) begin
      if (hold_tick != hold_seen) begin
         hold_seen <= hold_tick;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // Response checker: every accepted response against the oldest prediction
   always @(posedge clock) begin : check_rsp
      spmq_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            $error("response with no request outstanding: status %0d handle %h level %0d",
                   rsp_data.status, rsp_data.popped_handle, rsp_data.popped_level);
            n_errors++;
         end else begin
            want = awaited_rsp.pop_front();
            n_checked++;
            case (want.status)
               spmq_pkg::ST_POPPED:         n_popped++;
               spmq_pkg::ST_DROPPED:        n_dropped++;
               spmq_pkg::ST_EMPTY_RETRY:    n_retry++;
               spmq_pkg::ST_EMPTY_SHUTDOWN: n_shut++;
               default: ;
            endcase
            if (rsp_data.status !== want.status) begin
               $error("status mismatch: expected %0d, got %0d", want.status, rsp_data.status);
               n_errors++;
            end
            if (rsp_data.popped_handle !== want.popped_handle) begin
               $error("popped_handle mismatch: expected %h, got %h",
                      want.popped_handle, rsp_data.popped_handle);
               n_errors++;
            end
            if (rsp_data.popped_level !== want.popped_level) begin
               $error("popped_level mismatch: expected %0d, got %0d",
                      want.popped_level, rsp_data.popped_level);
               n_errors++;
            end
         end
      end
   end

   // Pop on empty queues, once per shutdown setting
   task automatic test_empty_pop;
      send_request(make_req(spmq_pkg::OP_POP, 2'd0, 16'h0000));
      write_csr(SHUTDOWN_ADDR, 32'h0000_0001);
      send_request(make_req(spmq_pkg::OP_POP, 2'd0, 16'h0000));
      write_csr(SHUTDOWN_ADDR, 32'h0000_0000);
   endtask

   // Strict priority and FIFO order within a level, plus the missing level
   task automatic test_priority_order;
      send_request(make_req(spmq_pkg::OP_PUSH, 2'd2, 16'hFFFF));
      send_request(make_req(spmq_pkg::OP_PUSH, 2'd1, 16'h0000));
      send_request(make_req(spmq_pkg::OP_PUSH, 2'd0, 16'h5A5A));
      send_request(make_req(spmq_pkg::OP_PUSH, 2'd0, 16'hA5A5));
      send_request(make_req(spmq_pkg::OP_PUSH, BAD_LEVEL, 16'h1234));
      repeat (5) send_request(make_req(spmq_pkg::OP_POP, 2'd0, 16'h0000));
   endtask

   // Register decode: unmapped index ignored, only bit 0 of shutdown kept,
   // pushes still accepted while shutting down
   task automatic test_csr_decode;
      write_csr(UNMAPPED_ADDR, 32'hFFFF_FFFF);
      send_request(make_req(spmq_pkg::OP_POP, 2'd3, 16'hFFFF));
      write_csr(SHUTDOWN_ADDR, 32'hFFFF_FFFE);
      send_request(make_req(spmq_pkg::OP_POP, 2'd0, 16'h0000));
      write_csr(SHUTDOWN_ADDR, 32'hFFFF_FFFF);
      send_request(make_req(spmq_pkg::OP_PUSH, 2'd1, 16'hBEEF));
      send_request(make_req(spmq_pkg::OP_POP, 2'd0, 16'h0000));
      send_request(make_req(spmq_pkg::OP_POP, 2'd0, 16'h0000));
      write_csr(SHUTDOWN_ADDR, 32'h0000_0000);
   endtask

   // Fill each level to DEPTH, overflow it by one, then empty it again
   task automatic test_level_full;
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         repeat (DEPTH + 1)
            send_request(make_req(spmq_pkg::OP_PUSH, 2'(lvl), 16'($urandom_range(65535))));
         repeat (DEPTH + 1) send_request(make_req(spmq_pkg::OP_POP, 2'd0, 16'h0000));
      end
   endtask

   // Long receiver hold-off while requests keep coming, so req_ready drops;
   // then the sender waits for every response before resuming
   task automatic test_backpressure;
      hold_tick <= ~hold_tick;
      repeat (24)
         send_request(make_req(spmq_pkg::opcode_type'($urandom_range(1)),
                               2'($urandom_range(2)), 16'($urandom_range(65535))));
      drain_responses();
      repeat (10)
         send_request(make_req(spmq_pkg::opcode_type'($urandom_range(1)),
                               2'($urandom_range(3)), 16'($urandom_range(65535))));
   endtask

   // Bursts biased toward push, pop or balanced so the levels swing between
   // empty and full; now and then an idle gap with a new shutdown value
   task automatic test_random_traffic(input int n_items);
      int sent;
      int push_pct;
      int burst_len;
      logic [1:0] lvl;
      spmq_pkg::req_type r;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(2))
            0: push_pct = 80;
            1: push_pct = 20;
            default: push_pct = 50;
         endcase
         burst_len = $urandom_range(8, 40);
         repeat (burst_len) begin
            lvl = ($urandom_range(15) == 0) ? BAD_LEVEL : 2'($urandom_range(LEVELS - 1));
            if ($urandom_range(99) < push_pct)
               r = make_req(spmq_pkg::OP_PUSH, lvl, 16'($urandom_range(65535)));
            else
               r = make_req(spmq_pkg::OP_POP, 2'($urandom_range(3)),
                            16'($urandom_range(65535)));
            send_request(r);
            sent++;
         end
         if ($urandom_range(3) == 0)
            write_csr(SHUTDOWN_ADDR, 32'($urandom));
      end
   endtask

   // Run limit: far beyond the slowest legal run of about 950 requests
   initial begin
      #2_000_000;
      $display("tb_strict_priority_multi_queue_top failed");
      $finish;
   end

   initial begin
      foreach (head_ptr[i]) begin
         head_ptr[i] = 0;
         tail_ptr[i] = 0;
         fill_cnt[i] = 0;
      end
      shutdown_copy = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Phase 1: sender idles 36%, receiver 49%
      send_idle_pct = 36;
      rcv_idle_pct = 49;
      test_empty_pop();
      test_priority_order();
      test_csr_decode();
      test_level_full();
      test_random_traffic(280);

      // Phase 2: roles swapped, with the long hold-off
      drain_responses();
      send_idle_pct = 49;
      rcv_idle_pct = 36;
      test_backpressure();
      test_random_traffic(280);

      // Phase 3: full rate on both sides
      drain_responses();
      send_idle_pct = 0;
      rcv_idle_pct = 0;
      test_random_traffic(250);

      drain_responses();
      $display("Sent %0d requests; checked %0d responses: %0d popped, %0d dropped,",
               n_sent, n_checked, n_popped, n_dropped);
      $display("%0d empty with retry, %0d empty with shutdown", n_retry, n_shut);
      if (n_errors == 0)
         $display("tb_strict_priority_multi_queue_top passed");
      else
         $display("tb_strict_priority_multi_queue_top failed");
      $finish;
   end

endmodule
